[design/assert_macros.svh]
// Assertion macros for the checker file of the block.
// Each macro wraps one clocked concurrent assertion with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define VMPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be seen at a clock edge out of reset
`define VMPL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/vmpl_pkg.sv]
// Package of the voice mix block peak limiter: widths, constants, register codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vmpl_pkg;

  localparam int BLOCK_SIZE = 64;
  localparam int ADDR_W     = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 17;
  localparam int THR_W    = 23;
  localparam int ACC_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIVD_W  = ACC_W + THR_W;
  localparam int DIV_CNT_W = $clog2(THR_W + 1);

  localparam int LO_W      = 42;
  localparam int RND_W     = 59;
  localparam int CONTRIB_W = 26;

  localparam logic [GAIN_W-1:0] UNITY          = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 17'd32768;
  localparam logic [THR_W-1:0]  THR_RESET      = 23'd7549747;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_GAIN    = 2'd0,
    REG_CHANNEL_VOLUME = 2'd1,
    REG_AGC_ENABLE     = 2'd2,
    REG_AGC_THRESHOLD  = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

[design/vmpl_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on vmpl_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module vmpl_mul import vmpl_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0]      p_o
);

  logic signed [MUL_P_W-1:0] p_d;
  logic signed [MUL_P_W-1:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[design/vmpl_div.sv]
// Restoring divider, one quotient bit per cycle, THR_W quotient bits.
// Needs dividend < divisor * 2^THR_W. Depends on vmpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmpl_div import vmpl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dividend_i,
  input  wire logic [ACC_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic [THR_W-1:0]       quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]     rem_q;
  logic [THR_W-1:0]     dlo_q;
  logic [THR_W-1:0]     quot_q;
  logic [ACC_W-1:0]     dvs_q;
  logic [ACC_W:0]       trial;
  logic                 ge;

  assign trial = {rem_q, dlo_q[THR_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(THR_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[DIVD_W-1:THR_W];
      dlo_q  <= dividend_i[THR_W-1:0];
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? ACC_W'(trial - {1'b0, dvs_q}) : trial[ACC_W-1:0];
      dlo_q  <= {dlo_q[THR_W-2:0], 1'b0};
      quot_q <= {quot_q[THR_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[design/voice_mix_block_peak_limiter_unit.sv]
// Voice mix block peak limiter: one mixer channel, sequenced over a shared multiplier.
// Per item: accept, gain, two partial products, round, buffer add; input closed meanwhile.
// Block end: peak scan (read, compare per entry), then per entry read, calc, output plus output stall,
// and with limiting a multiply and a 23-step serial divider before each output.
// Async active-low reset: config to defaults, buffer reads as zero, position zero.
`timescale 1ns / 1ps
`default_nettype none

module voice_mix_block_peak_limiter_unit import vmpl_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] voice_sample
  input  wire logic                  s_axis_tlast,   // last_voice
  input  wire logic                  s_axis_tuser,   // last_sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]        m_axis_tdata,   // [23:0] out_sample
  output logic                       m_axis_tlast,   // block_end
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_GAIN     = 14'b00000000000010,
    ST_LO       = 14'b00000000000100,
    ST_HI       = 14'b00000000001000,
    ST_RND      = 14'b00000000010000,
    ST_ACC      = 14'b00000000100000,
    ST_SCAN_RD  = 14'b00000001000000,
    ST_SCAN_CMP = 14'b00000010000000,
    ST_DECIDE   = 14'b00000100000000,
    ST_EM_RD    = 14'b00001000000000,
    ST_EM_CALC  = 14'b00010000000000,
    ST_EM_MUL   = 14'b00100000000000,
    ST_EM_DIV   = 14'b01000000000000,
    ST_EM_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [GAIN_W-1:0] mg_q, cv_q;
  logic              agc_q;
  logic [THR_W-1:0]  thr_q;

  logic signed [SAMPLE_W-1:0] smp_q;
  logic                       lv_q, ls_q;
  logic [ADDR_W-1:0]          pos_q, idx_q;
  logic [2*GAIN_W-2:0]        gq_q;
  logic [LO_W-1:0]            lo_q;
  logic [CONTRIB_W-1:0]       c_q;
  logic [ACC_W-1:0]           peak_q;
  logic                       limit_q, xneg_q;

  logic [ACC_W-1:0]      mem_q [BLOCK_SIZE];
  logic [BLOCK_SIZE-1:0] vld_q;
  logic [ACC_W-1:0]      rd_q;
  logic                  rd_vld_q;
  logic [ADDR_W-1:0]     rd_addr;

  logic                ov_q, ol_q;
  logic [SAMPLE_W-1:0] od_q;

  logic [GAIN_W-1:0]         mgc, cvc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [MUL_A_W-1:0]        smp_x;
  logic [ACC_W-1:0]          ent, ent_mag;
  logic [RND_W-1:0]          rnd_sum;
  logic [ACC_W:0]            acc_sum;
  logic [ACC_W-1:0]          acc_sat;
  logic [SAMPLE_W-1:0]       ent_sat, div_y;
  logic                      div_start, div_done;
  logic [THR_W-1:0]          quot;
  logic                      s_acc, m_acc, at_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_acc         = ov_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign at_last       = (idx_q == pos_q);

  assign mgc = (mg_q > UNITY) ? UNITY : mg_q;
  assign cvc = (cv_q > UNITY) ? UNITY : cv_q;

  assign smp_x   = {{(MUL_A_W-SAMPLE_W){smp_q[SAMPLE_W-1]}}, smp_q};
  assign ent     = rd_vld_q ? rd_q : '0;
  assign ent_mag = ent[ACC_W-1] ? (ACC_W'(0) - ent) : ent;

  // contribution = floor((s*g + 2^31) / 2^32), built from two partial products
  assign rnd_sum = {mul_p[RND_W-17:0], 16'b0} + {{(RND_W-LO_W){lo_q[LO_W-1]}}, lo_q};

  assign acc_sum = {ent[ACC_W-1], ent}
                 + {{(ACC_W+1-CONTRIB_W){c_q[CONTRIB_W-1]}}, c_q};
  assign acc_sat = (acc_sum[ACC_W] == acc_sum[ACC_W-1]) ? acc_sum[ACC_W-1:0] :
                   (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}});

  assign ent_sat = (ent[ACC_W-1:SAMPLE_W-1] == '0 || ent[ACC_W-1:SAMPLE_W-1] == '1) ?
                   ent[SAMPLE_W-1:0] :
                   (ent[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} :
                                   {1'b0, {(SAMPLE_W-1){1'b1}}});

  assign div_y = xneg_q ? (SAMPLE_W'(0) - {1'b0, quot}) : {1'b0, quot};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GAIN: begin
        mul_a = $signed(MUL_A_W'(mgc));
        mul_b = $signed(MUL_B_W'(cvc));
      end
      ST_LO: begin
        mul_a = $signed(smp_x);
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, mul_p[15:0]});
      end
      ST_HI: begin
        mul_a = $signed(smp_x);
        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gq_q[2*GAIN_W-2:16]});
      end
      ST_EM_CALC: begin
        mul_a = $signed({1'b0, ent_mag});
        mul_b = $signed({1'b0, thr_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vmpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign div_start = (state_q == ST_EM_MUL);

  vmpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[DIVD_W-1:0]),
    .divisor_i  (peak_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_acc) state_d = ST_GAIN;
      ST_GAIN:     state_d = ST_LO;
      ST_LO:       state_d = ST_HI;
      ST_HI:       state_d = ST_RND;
      ST_RND:      state_d = ST_ACC;
      ST_ACC:      state_d = (lv_q && ls_q) ? ST_SCAN_RD : ST_IDLE;
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = at_last ? ST_DECIDE : ST_SCAN_RD;
      ST_DECIDE:   state_d = ST_EM_RD;
      ST_EM_RD:    state_d = ST_EM_CALC;
      ST_EM_CALC:  state_d = limit_q ? ST_EM_MUL : ST_EM_OUT;
      ST_EM_MUL:   state_d = ST_EM_DIV;
      ST_EM_DIV:   if (div_done) state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (m_acc) state_d = at_last ? ST_IDLE : ST_EM_RD;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mg_q    <= GAIN_RESET;
      cv_q    <= GAIN_RESET;
      agc_q   <= 1'b1;
      thr_q   <= THR_RESET;
      pos_q   <= '0;
      idx_q   <= '0;
      vld_q   <= '0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
      peak_q  <= '0;
      limit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MASTER_GAIN:    mg_q  <= cfg_data_i[GAIN_W-1:0];
          REG_CHANNEL_VOLUME: cv_q  <= cfg_data_i[GAIN_W-1:0];
          REG_AGC_ENABLE:     agc_q <= cfg_data_i[0];
          REG_AGC_THRESHOLD:  thr_q <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_ACC: begin
          vld_q[pos_q] <= 1'b1;
          if (lv_q && ls_q) begin
            idx_q  <= '0;
            peak_q <= '0;
          end else if (lv_q && pos_q != ADDR_W'(BLOCK_SIZE - 1)) begin
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_SCAN_CMP: begin
          if (ent_mag > peak_q) peak_q <= ent_mag;
          if (!at_last) idx_q <= idx_q + 1'b1;
        end
        ST_DECIDE: begin
          limit_q <= agc_q && (peak_q > ACC_W'(thr_q));
          idx_q   <= '0;
        end
        ST_EM_CALC: begin
          vld_q[idx_q] <= 1'b0;
          if (!limit_q) begin
            ov_q <= 1'b1;
            ol_q <= at_last;
          end
        end
        ST_EM_DIV: begin
          if (div_done) begin
            ov_q <= 1'b1;
            ol_q <= at_last;
          end
        end
        ST_EM_OUT: begin
          if (m_acc) begin
            ov_q <= 1'b0;
            if (at_last) pos_q <= '0;
            else idx_q <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          smp_q <= $signed(s_axis_tdata);
          lv_q  <= s_axis_tlast;
          ls_q  <= s_axis_tuser;
        end
      end
      ST_LO:      gq_q   <= mul_p[2*GAIN_W-2:0];
      ST_HI:      lo_q   <= mul_p[LO_W-1:0] + (LO_W'(1) << 31);
      ST_RND:     c_q    <= rnd_sum[32+CONTRIB_W-1:32];
      ST_EM_CALC: begin
        xneg_q <= ent[ACC_W-1];
        if (!limit_q) od_q <= ent_sat;
      end
      ST_EM_DIV:  if (div_done) od_q <= div_y;
      default: ;
    endcase
  end

  // entry to accumulate is read in the round cycle, ready for the add
  assign rd_addr = (state_q == ST_RND) ? pos_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) mem_q[pos_q] <= acc_sat;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/vmpl_checker.sv]
// Port-level checker for the voice mix block peak limiter, bound to the top level.
// Depends on assert_macros.svh and vmpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vmpl_checker import vmpl_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [SAMPLE_W-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  // input side stays closed while a block is being sent
  `VMPL_ASSERT_NEVER(a_no_in_during_out, clk_i, rst_ni, s_axis_tready && m_axis_tvalid, "input open while output beat pending")

  `VMPL_ASSERT(a_busy_after_beat, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input ready right after an accepted beat")

  `VMPL_ASSERT(a_idle_after_end, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid, "output beat right after block end")

  `VMPL_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output beat changed")

endmodule

bind voice_mix_block_peak_limiter_unit vmpl_checker u_vmpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[dv/tb_voice_mix_block_peak_limiter_unit.sv]
`timescale 1ns / 1ps
// Testbench of voice_mix_block_peak_limiter_unit: directed blocks, then random blocks in phases.
// Depends on vmpl_pkg and the block's RTL; a scoreboard class predicts every emitted block.

module tb_voice_mix_block_peak_limiter_unit;
  import vmpl_pkg::*;

  localparam int     LIMIT      = 5000000;
  localparam int     QUIET      = 80;
  localparam int     RAND_ITEMS = 180;
  localparam int     PHASES     = 8;
  localparam int     PILE_DEPTH = 260;
  localparam longint ACC_MAX    = 64'sd2147483647;
  localparam longint ACC_MIN    = -64'sd2147483648;
  localparam longint OUT_MAX    = 64'sd8388607;
  localparam longint OUT_MIN    = -64'sd8388608;
  localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;
  localparam logic [THR_W-1:0]    T_MAX = 23'h7FFFFF;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                blk_end;
  } mix_beat_t;

  class mix_scoreboard;
    logic [GAIN_W-1:0] master_gain;
    logic [GAIN_W-1:0] channel_volume;
    logic              agc_on;
    logic [THR_W-1:0]  agc_thr;
    longint            acc [BLOCK_SIZE];
    int                wr_pos;
    mix_beat_t         block_q[$];
    int                errors;

    function new();
      master_gain    = GAIN_RESET;
      channel_volume = GAIN_RESET;
      agc_on         = 1'b1;
      agc_thr        = THR_RESET;
      foreach (acc[i]) acc[i] = 0;
      wr_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MASTER_GAIN:    master_gain    = v[GAIN_W-1:0];
        REG_CHANNEL_VOLUME: channel_volume = v[GAIN_W-1:0];
        REG_AGC_ENABLE:     agc_on         = v[0];
        REG_AGC_THRESHOLD:  agc_thr        = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_voice(logic [SAMPLE_W-1:0] smp, logic lv, logic ls);
      longint    s, g, mg, cv, sum, peak, mag, q, y;
      bit        lim;
      int        n;
      mix_beat_t b;
      mg  = (master_gain > UNITY) ? UNITY : master_gain;
      cv  = (channel_volume > UNITY) ? UNITY : channel_volume;
      g   = mg * cv;
      s   = $signed(smp);
      sum = acc[wr_pos] + ((s * g + (longint'(1) << 31)) >>> 32);
      acc[wr_pos] = (sum > ACC_MAX) ? ACC_MAX : ((sum < ACC_MIN) ? ACC_MIN : sum);
      if (!lv) return;
      if (!ls) begin
        if (wr_pos < BLOCK_SIZE - 1) wr_pos++;
        return;
      end
      n    = wr_pos + 1;
      peak = 0;
      for (int i = 0; i < n; i++) begin
        mag = (acc[i] < 0) ? -acc[i] : acc[i];
        if (mag > peak) peak = mag;
      end
      lim = agc_on && (peak > longint'(agc_thr));
      for (int i = 0; i < n; i++) begin
        if (lim) begin
          mag = (acc[i] < 0) ? -acc[i] : acc[i];
          q   = (mag * longint'(agc_thr)) / peak;
          y   = (acc[i] < 0) ? -q : q;
        end else begin
          y = (acc[i] > OUT_MAX) ? OUT_MAX : ((acc[i] < OUT_MIN) ? OUT_MIN : acc[i]);
        end
        b.sample  = y[SAMPLE_W-1:0];
        b.blk_end = (i == n - 1);
        block_q.push_back(b);
        acc[i] = 0;
      end
      wr_pos = 0;
    endfunction

    function void check_out(logic [SAMPLE_W-1:0] smp, logic be);
      mix_beat_t b;
      if (block_q.size() == 0) begin
        $error("unexpected output beat: out_sample %0d block_end %0d", $signed(smp), be);
        errors++;
        return;
      end
      b = block_q.pop_front();
      if (smp !== b.sample) begin
        $error("out_sample mismatch: expected %0d actual %0d", $signed(b.sample), $signed(smp));
        errors++;
      end
      if (be !== b.blk_end) begin
        $error("block_end mismatch: expected %0d actual %0d", b.blk_end, be);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = REG_MASTER_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit            tx_fast = 1'b0;
  bit            rx_fast = 1'b0;
  bit            rx_hold = 1'b0;
  bit            hold_go = 1'b0;
  int            rand_sent = 0;
  int            cycles = 0;
  mix_scoreboard sb;

  voice_mix_block_peak_limiter_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // handshakes are sampled at the falling edge, where nothing is in motion
  task automatic push_voice(input logic [SAMPLE_W-1:0] smp, input logic lv, input logic ls);
    int gap;
    bit hs;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lv;
    s_tuser  <= ls;
    do begin
      @(negedge clk);
      hs = s_tready;
      @(posedge clk);
    end while (!hs);
    sb.note_voice(smp, lv, ls);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.block_q.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_beat(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    sb.write_reg(idx, v);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] mg, input logic [GAIN_W-1:0] cv,
                              input logic en, input logic [THR_W-1:0] thr);
    settle();
    write_beat(REG_MASTER_GAIN, CFG_DATA_W'(mg));
    write_beat(REG_CHANNEL_VOLUME, CFG_DATA_W'(cv));
    write_beat(REG_AGC_ENABLE, CFG_DATA_W'(en));
    write_beat(REG_AGC_THRESHOLD, CFG_DATA_W'(thr));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_block();
    int                  npos, nv, r;
    logic [SAMPLE_W-1:0] smp;
    logic                lv, ls;
    r = $urandom_range(0, 9);
    if (r < 6) npos = $urandom_range(1, 8);
    else if (r < 8) npos = $urandom_range(9, 40);
    else if (r == 8) npos = BLOCK_SIZE;
    else npos = $urandom_range(BLOCK_SIZE + 1, BLOCK_SIZE + 6);
    tx_fast = ($urandom_range(0, 5) == 0);
    rx_fast = ($urandom_range(0, 5) == 0);
    for (int p = 0; p < npos; p++) begin
      nv = (npos <= 8) ? $urandom_range(1, 4) : 1;
      for (int v = 0; v < nv; v++) begin
        smp = rand_sample();
        lv  = (v == nv - 1);
        ls  = lv && (p == npos - 1);
        if (!ls && $urandom_range(0, 15) == 0) ls = 1'b1;
        push_voice(smp, lv, ls);
        rand_sent++;
      end
    end
  endtask

  // full-scale negative voices stacked on one entry until the sum clips
  task automatic pile_up();
    tx_fast = 1'b1;
    for (int i = 0; i < PILE_DEPTH; i++) push_voice(S_MIN, 1'b0, 1'b0);
    push_voice(S_MIN, 1'b1, 1'b1);
    tx_fast = 1'b0;
  endtask

  initial begin : rx_side
    int                  rx_gap;
    bit                  hs;
    logic [SAMPLE_W-1:0] d;
    logic                l;
    rx_gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hs = m_tvalid && m_tready;
      d  = m_tdata;
      l  = m_tlast;
      @(posedge clk);
      if (hs) begin
        sb.check_out(d, l);
        rx_gap = rx_fast ? 0 : $urandom_range(0, 14);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      m_tready <= (rx_gap == 0) && !rx_hold;
    end
  end

  initial begin : rx_backpressure
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (1500) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main_seq
    logic [GAIN_W-1:0] mg, cv;
    logic              en;
    logic [THR_W-1:0]  thr;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, single-entry block
    push_voice(S_MAX, 1'b1, 1'b1);
    // last_sample without last_voice does not end the block
    push_voice(S_MIN, 1'b1, 1'b0);
    push_voice('0, 1'b0, 1'b1);
    push_voice(24'd1, 1'b1, 1'b1);

    // unity gain, peak over threshold
    program_regs(UNITY, UNITY, 1'b1, THR_RESET);
    push_voice(S_MIN, 1'b0, 1'b0);
    push_voice(S_MIN, 1'b1, 1'b0);
    push_voice(S_MAX, 1'b1, 1'b1);

    // limiter off: plain saturation both ways
    program_regs(UNITY, UNITY, 1'b0, THR_RESET);
    push_voice(S_MAX, 1'b0, 1'b0);
    push_voice(S_MAX, 1'b1, 1'b0);
    push_voice(S_MIN, 1'b0, 1'b0);
    push_voice(S_MIN, 1'b1, 1'b1);

    // zero threshold
    program_regs(UNITY, UNITY, 1'b1, '0);
    push_voice(24'd5, 1'b1, 1'b0);
    push_voice('0, 1'b1, 1'b1);
    push_voice('0, 1'b1, 1'b1);

    // gains above one clamp to unity
    program_regs('1, UNITY + 17'd1, 1'b1, T_MAX);
    push_voice(S_MAX, 1'b0, 1'b0);
    push_voice(S_MAX, 1'b1, 1'b1);

    program_regs('0, UNITY, 1'b1, T_MAX);
    push_voice(S_MAX, 1'b1, 1'b0);
    push_voice(S_MIN, 1'b1, 1'b1);

    // peak equal to threshold is not limited
    program_regs(UNITY, UNITY, 1'b1, T_MAX);
    push_voice(S_MAX, 1'b1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      mg  = GAIN_W'($urandom_range(0, 131071));
      cv  = GAIN_W'($urandom_range(0, 131071));
      en  = 1'($urandom());
      thr = THR_W'($urandom());
      case (ph)
        0: en = 1'b1;
        1: begin mg = 17'd1; cv = UNITY; end
        2: begin mg = UNITY; cv = UNITY; end
        3: begin mg = '1; cv = GAIN_W'($urandom_range(65537, 131071)); en = 1'b0; end
        4: begin mg = UNITY; cv = UNITY; en = 1'b1; thr = T_MAX; end
        5: begin mg = UNITY; cv = UNITY; en = 1'b1; thr = THR_W'($urandom_range(0, 1000)); end
        default: ;
      endcase
      program_regs(mg, cv, en, thr);
      if (ph == 2) pile_up();
      if (ph == 4) hold_go = 1'b1;
      do send_block(); while (rand_sent < (ph + 1) * RAND_ITEMS / PHASES);
    end

    settle();
    if (sb.errors == 0 && sb.block_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[voice_mix_block_peak_limiter_unit.f]
+incdir+design
design/vmpl_pkg.sv
design/vmpl_mul.sv
design/vmpl_div.sv
design/voice_mix_block_peak_limiter_unit.sv
design/vmpl_checker.sv
dv/tb_voice_mix_block_peak_limiter_unit.sv
